/* design/pais_pkg.sv */
// Shared types, constants and tables for the pixel adaptive IIR smoother.
`timescale 1ns / 1ps
`default_nettype none
package pais_pkg;

  // Field widths
  localparam int TEMP_W  = 18;
  localparam int IDX_W   = 8;
  localparam int THR_W   = 17;
  localparam int DEPTH_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam int PIXELS = 192;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_DEPTH  = 2'd2;

  localparam logic             RST_FILTER_ENABLE  = 1'b1;
  localparam logic [THR_W-1:0]   RST_JUMP_THRESHOLD = 17'd320;
  localparam logic [DEPTH_W-1:0] RST_AVERAGE_DEPTH  = 5'd8;

  // Valid band, -100 C .. 1000 C in 1/128 C
  localparam logic signed [TEMP_W-1:0] BAND_LOW  = -18'sd12800;
  localparam logic signed [TEMP_W-1:0] BAND_HIGH = 18'sd128000;

  // Datapath widths
  localparam int DIFF_W  = TEMP_W + 1;
  localparam int FAST_W  = 36;
  localparam int FAST_GAIN = 58982;   // 0.9 in Q16
  localparam int FAST_SHIFT = 16;
  localparam int SUM_W   = 24;
  localparam int MAG_W   = 22;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam int STAGES  = 4;

  // ceil(2^28 / d); depth zero acts as one. Exact for numerators below 2^22.
  localparam logic [RECIP_W-1:0] RECIP_TABLE [2**DEPTH_W] = '{
    RECIP_W'((2**RECIP_SHIFT + 0)  / 1),  RECIP_W'((2**RECIP_SHIFT + 0)  / 1),
    RECIP_W'((2**RECIP_SHIFT + 1)  / 2),  RECIP_W'((2**RECIP_SHIFT + 2)  / 3),
    RECIP_W'((2**RECIP_SHIFT + 3)  / 4),  RECIP_W'((2**RECIP_SHIFT + 4)  / 5),
    RECIP_W'((2**RECIP_SHIFT + 5)  / 6),  RECIP_W'((2**RECIP_SHIFT + 6)  / 7),
    RECIP_W'((2**RECIP_SHIFT + 7)  / 8),  RECIP_W'((2**RECIP_SHIFT + 8)  / 9),
    RECIP_W'((2**RECIP_SHIFT + 9)  / 10), RECIP_W'((2**RECIP_SHIFT + 10) / 11),
    RECIP_W'((2**RECIP_SHIFT + 11) / 12), RECIP_W'((2**RECIP_SHIFT + 12) / 13),
    RECIP_W'((2**RECIP_SHIFT + 13) / 14), RECIP_W'((2**RECIP_SHIFT + 14) / 15),
    RECIP_W'((2**RECIP_SHIFT + 15) / 16), RECIP_W'((2**RECIP_SHIFT + 16) / 17),
    RECIP_W'((2**RECIP_SHIFT + 17) / 18), RECIP_W'((2**RECIP_SHIFT + 18) / 19),
    RECIP_W'((2**RECIP_SHIFT + 19) / 20), RECIP_W'((2**RECIP_SHIFT + 20) / 21),
    RECIP_W'((2**RECIP_SHIFT + 21) / 22), RECIP_W'((2**RECIP_SHIFT + 22) / 23),
    RECIP_W'((2**RECIP_SHIFT + 23) / 24), RECIP_W'((2**RECIP_SHIFT + 24) / 25),
    RECIP_W'((2**RECIP_SHIFT + 25) / 26), RECIP_W'((2**RECIP_SHIFT + 26) / 27),
    RECIP_W'((2**RECIP_SHIFT + 27) / 28), RECIP_W'((2**RECIP_SHIFT + 28) / 29),
    RECIP_W'((2**RECIP_SHIFT + 29) / 30), RECIP_W'((2**RECIP_SHIFT + 30) / 31)
  };

  // Store write port
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         idx;
    logic signed [TEMP_W-1:0] data;
  } wr_t;

  // Pixels held by the pipeline that will still write the store
  typedef struct packed {
    logic [STAGES-1:0]            busy;
    logic [STAGES-1:0][IDX_W-1:0] idx;
  } inflight_t;

endpackage
`default_nettype wire

/* design/pais_store.sv */
// Per-pixel smoothed value memory and primed bits.
`timescale 1ns / 1ps
`default_nettype none
module pais_store (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  rd_en,
  input  wire logic [pais_pkg::IDX_W-1:0]            rd_idx,
  input  wire pais_pkg::wr_t                         wr,
  output logic signed [pais_pkg::TEMP_W-1:0]         rd_data_r,
  output logic                                       rd_primed_r
);

  logic signed [pais_pkg::TEMP_W-1:0] mem [pais_pkg::PIXELS];
  logic [pais_pkg::PIXELS-1:0] primed_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= '0;
      rd_primed_r <= 1'b0;
    end else begin
      if (wr.en) begin
        primed_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_primed_r <= primed_r[rd_idx];
      end
    end
  end

endmodule
`default_nettype wire

/* design/pais_pipe.sv */
// Four-stage smoothing datapath: seed/diff, scale, divide multiply, select.
`timescale 1ns / 1ps
`default_nettype none
module pais_pipe (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  adv,
  input  wire logic                                  in_take,
  input  wire logic                                  in_active,
  input  wire logic signed [pais_pkg::TEMP_W-1:0]    in_x,
  input  wire logic [pais_pkg::IDX_W-1:0]            in_idx,
  input  wire logic signed [pais_pkg::TEMP_W-1:0]    in_amb,
  input  wire logic signed [pais_pkg::TEMP_W-1:0]    old_val,
  input  wire logic                                  old_primed,
  input  wire logic [pais_pkg::THR_W-1:0]            thr,
  input  wire logic [pais_pkg::DEPTH_W-1:0]          depth,
  output pais_pkg::inflight_t                        inflight,
  output pais_pkg::wr_t                              wr,
  output logic                                       res_valid,
  output logic signed [pais_pkg::TEMP_W-1:0]         res_temp,
  output logic [pais_pkg::IDX_W-1:0]                 res_idx
);

  localparam int TW = pais_pkg::TEMP_W;
  localparam int IW = pais_pkg::IDX_W;

  // Stage A
  logic a_v_r, a_act_r;
  logic signed [TW-1:0] a_x_r, a_amb_r;
  logic [IW-1:0] a_idx_r;

  logic signed [TW-1:0] a_base;
  logic signed [pais_pkg::DIFF_W-1:0] a_diff;
  logic [pais_pkg::DIFF_W-1:0] a_mag;
  logic a_fast, a_band;
  logic [pais_pkg::DEPTH_W-1:0] a_dm1;
  logic signed [pais_pkg::SUM_W-1:0] a_base_ext, a_dm1_ext, a_sum;
  logic signed [pais_pkg::FAST_W-1:0] a_diff_ext, a_gain, a_prodf;

  always_comb begin
    if (old_primed) begin
      a_base = old_val;
    end else if (a_x_r > pais_pkg::BAND_LOW && a_x_r < pais_pkg::BAND_HIGH) begin
      a_base = a_x_r;
    end else begin
      a_base = a_amb_r;
    end
    a_band = (a_x_r >= pais_pkg::BAND_LOW) && (a_x_r <= pais_pkg::BAND_HIGH);
    a_diff = pais_pkg::DIFF_W'(a_x_r) - pais_pkg::DIFF_W'(a_base);
    a_mag  = a_diff[pais_pkg::DIFF_W-1] ? pais_pkg::DIFF_W'(-a_diff) : a_diff;
    a_fast = a_mag >= pais_pkg::DIFF_W'(thr);
    a_dm1  = (depth == '0) ? '0 : depth - 1'b1;
    a_base_ext = pais_pkg::SUM_W'(a_base);
    a_dm1_ext  = pais_pkg::SUM_W'({1'b0, a_dm1});
    a_sum      = pais_pkg::SUM_W'(a_x_r) + a_base_ext * a_dm1_ext;
    a_diff_ext = pais_pkg::FAST_W'(a_diff);
    a_gain     = pais_pkg::FAST_W'(pais_pkg::FAST_GAIN);
    a_prodf    = a_diff_ext * a_gain;
  end

  // Stage B
  logic b_v_r, b_act_r, b_band_r, b_fast_r;
  logic signed [TW-1:0] b_x_r, b_base_r;
  logic [IW-1:0] b_idx_r;
  logic signed [pais_pkg::SUM_W-1:0] b_sum_r;
  logic signed [pais_pkg::FAST_W-1:0] b_prodf_r;

  logic signed [TW+1:0] b_fast_sum;
  logic [pais_pkg::SUM_W-1:0] b_abs;

  always_comb begin
    b_fast_sum = (TW+2)'(b_base_r) + $signed(b_prodf_r[pais_pkg::FAST_W-1:pais_pkg::FAST_SHIFT]);
    b_abs      = b_sum_r[pais_pkg::SUM_W-1] ? pais_pkg::SUM_W'(-b_sum_r) : b_sum_r;
  end

  // Stage C
  logic c_v_r, c_act_r, c_band_r, c_fast_r, c_neg_r;
  logic signed [TW-1:0] c_x_r, c_base_r, c_fastval_r;
  logic [IW-1:0] c_idx_r;
  logic [pais_pkg::MAG_W-1:0] c_mag_r;
  logic [pais_pkg::RECIP_W-1:0] c_recip_r;
  logic [pais_pkg::PROD_W-1:0] c_prodq;

  assign c_prodq = pais_pkg::PROD_W'(c_mag_r) * pais_pkg::PROD_W'(c_recip_r);

  // Stage D
  logic d_v_r, d_act_r, d_band_r, d_fast_r, d_neg_r;
  logic signed [TW-1:0] d_x_r, d_base_r, d_fastval_r;
  logic [IW-1:0] d_idx_r;
  logic [pais_pkg::PROD_W-1:0] d_prodq_r;

  logic [pais_pkg::MAG_W-1:0] d_q, d_qn;
  logic signed [TW-1:0] d_avg, d_res;

  always_comb begin
    d_q   = d_prodq_r[pais_pkg::RECIP_SHIFT +: pais_pkg::MAG_W];
    d_qn  = -d_q;
    d_avg = d_neg_r ? d_qn[TW-1:0] : d_q[TW-1:0];
    if (!d_act_r) begin
      d_res = d_x_r;
    end else if (!d_band_r) begin
      d_res = d_base_r;
    end else if (d_fast_r) begin
      d_res = d_fastval_r;
    end else begin
      d_res = d_avg;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_take;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_act_r <= in_active;
      a_x_r   <= in_x;
      a_idx_r <= in_idx;
      a_amb_r <= in_amb;

      b_act_r   <= a_act_r;
      b_band_r  <= a_band;
      b_fast_r  <= a_fast;
      b_x_r     <= a_x_r;
      b_base_r  <= a_base;
      b_idx_r   <= a_idx_r;
      b_sum_r   <= a_sum;
      b_prodf_r <= a_prodf;

      c_act_r     <= b_act_r;
      c_band_r    <= b_band_r;
      c_fast_r    <= b_fast_r;
      c_neg_r     <= b_sum_r[pais_pkg::SUM_W-1];
      c_x_r       <= b_x_r;
      c_base_r    <= b_base_r;
      c_fastval_r <= b_fast_sum[TW-1:0];
      c_idx_r     <= b_idx_r;
      c_mag_r     <= b_abs[pais_pkg::MAG_W-1:0];
      c_recip_r   <= pais_pkg::RECIP_TABLE[depth];

      d_act_r     <= c_act_r;
      d_band_r    <= c_band_r;
      d_fast_r    <= c_fast_r;
      d_neg_r     <= c_neg_r;
      d_x_r       <= c_x_r;
      d_base_r    <= c_base_r;
      d_fastval_r <= c_fastval_r;
      d_idx_r     <= c_idx_r;
      d_prodq_r   <= c_prodq;
    end
  end

  assign inflight.busy = {d_v_r & d_act_r, c_v_r & c_act_r, b_v_r & b_act_r, a_v_r & a_act_r};
  assign inflight.idx  = {d_idx_r, c_idx_r, b_idx_r, a_idx_r};

  assign wr.en   = adv & d_v_r & d_act_r;
  assign wr.idx  = d_idx_r;
  assign wr.data = d_res;

  assign res_valid = d_v_r;
  assign res_temp  = d_res;
  assign res_idx   = d_idx_r;

endmodule
`default_nettype wire

/* design/pixel_adaptive_iir_smoother_unit.sv */
// Top level of the per-pixel adaptive temporal smoother.
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel temporal smoother for a 192-pixel thermal array, temperatures in
// signed 1/128 C. Each input transaction carries one pixel sample, its index
// and the frame ambient; each produces exactly one output transaction with the
// smoothed value and the index, in order. A pixel seen for the first time is
// seeded (its own value if strictly inside -100..1000 C, else the ambient);
// in-band samples then either add 0.9 of a large step or fold into a running
// average of depth average_depth. Disabled filter or index >= 192 passes the
// sample through and leaves the state alone. Throughput is one transaction
// per cycle while out_tready does not hold the output and no index hazard
// stalls the input; an accepted sample passes the four datapath stages and
// then the output register. The store is read at acceptance and written when
// an item leaves the last stage, so a sample whose index matches an enabled
// item still in the four datapath stages is held off until that item has
// written back; an index repeating within four samples can stall the input.
// Primed bits clear in the reset cycle; no clearing pass is needed.
// Configuration is accepted every cycle and must be written only while the block is idle.
module pixel_adaptive_iir_smoother_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata: pixel_temp[17:0], pixel_index[25:18], ambient_temp[43:26], zero pad
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [pais_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata: filtered_temp[17:0], pixel_index_out[25:18], zero pad
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [pais_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pais_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pais_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TW = pais_pkg::TEMP_W;
  localparam int IW = pais_pkg::IDX_W;

  // Config registers
  logic                          filter_enable_r;
  logic [pais_pkg::THR_W-1:0]    jump_threshold_r;
  logic [pais_pkg::DEPTH_W-1:0]  average_depth_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_enable_r  <= pais_pkg::RST_FILTER_ENABLE;
      jump_threshold_r <= pais_pkg::RST_JUMP_THRESHOLD;
      average_depth_r  <= pais_pkg::RST_AVERAGE_DEPTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        pais_pkg::REG_FILTER_ENABLE:  filter_enable_r  <= cfg_data[0];
        pais_pkg::REG_JUMP_THRESHOLD: jump_threshold_r <= cfg_data[pais_pkg::THR_W-1:0];
        pais_pkg::REG_AVERAGE_DEPTH:  average_depth_r  <= cfg_data[pais_pkg::DEPTH_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Input field unpack
  logic signed [TW-1:0] in_x, in_amb;
  logic [IW-1:0]        in_idx;

  assign in_x   = in_tdata[TW-1:0];
  assign in_idx = in_tdata[TW +: IW];
  assign in_amb = in_tdata[TW+IW +: TW];

  // Sample touches the store only when filtering and index is in range
  logic in_active;
  assign in_active = filter_enable_r && (in_idx < IW'(pais_pkg::PIXELS));

  // Whole pipe moves when the output register is free or being drained
  logic out_valid_r;
  logic adv;
  assign adv = !out_valid_r || out_tready;

  // Read-after-write interlock against pixels still in flight
  pais_pkg::inflight_t inflight;
  logic hazard;

  always_comb begin
    hazard = 1'b0;
    for (int i = 0; i < pais_pkg::STAGES; i++) begin
      if (inflight.busy[i] && inflight.idx[i] == in_idx) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_tready = adv && !hazard;

  logic in_take;
  assign in_take = in_tvalid && in_tready;

  // Store
  pais_pkg::wr_t        wr;
  logic signed [TW-1:0] old_val;
  logic                 old_primed;

  pais_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .rd_en       (in_take && in_active),
    .rd_idx      (in_idx),
    .wr          (wr),
    .rd_data_r   (old_val),
    .rd_primed_r (old_primed)
  );

  // Datapath
  logic                 res_valid;
  logic signed [TW-1:0] res_temp;
  logic [IW-1:0]        res_idx;

  pais_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_take    (in_take),
    .in_active  (in_active),
    .in_x       (in_x),
    .in_idx     (in_idx),
    .in_amb     (in_amb),
    .old_val    (old_val),
    .old_primed (old_primed),
    .thr        (jump_threshold_r),
    .depth      (average_depth_r),
    .inflight   (inflight),
    .wr         (wr),
    .res_valid  (res_valid),
    .res_temp   (res_temp),
    .res_idx    (res_idx)
  );

  // Output register
  logic signed [TW-1:0] out_temp_r;
  logic [IW-1:0]        out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_temp_r <= res_temp;
      out_idx_r  <= res_idx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(pais_pkg::OUT_DATA_W-TW-IW)'(0), out_idx_r, out_temp_r};

endmodule
`default_nettype wire
